// ----- sv/tlb_with_page_table_walk_defines.svh -----
// ----------------------------------------------------------------------------
// TLB with page table walk: assertion macros
// Concurrent assertion helpers used by the top level; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef TLB_WITH_PAGE_TABLE_WALK_DEFINES_SVH
`define TLB_WITH_PAGE_TABLE_WALK_DEFINES_SVH
`ifndef SYNTH
`define TLBW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlbw assertion failed");
`define TLBW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlbw assertion failed");
`else
`define TLBW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TLBW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/tlbw_pkg.sv -----
// ----------------------------------------------------------------------------
// TLB with page table walk: package
// Sizes, operation and register codes, payload structs and sequencer states.
// ----------------------------------------------------------------------------
package tlbw_pkg;

	localparam int OFFSET_BITS   = 12;
	localparam int VPN_BITS      = 12;
	localparam int PPN_BITS      = 16;
	localparam int REQ_ENTRIES   = 64;
	localparam int TLB_WAYS      = 4;
	localparam int REQUESTERS    = 4;
	localparam int EFF_WAYS      = (TLB_WAYS > REQ_ENTRIES) ? REQ_ENTRIES : TLB_WAYS;
	localparam int SET_COUNT     = REQ_ENTRIES / EFF_WAYS;
	localparam int TLB_TOTAL     = REQUESTERS * REQ_ENTRIES;
	localparam int PT_DEPTH      = 1 << VPN_BITS;
	localparam int WAY_BITS      = (EFF_WAYS > 1) ? $clog2(EFF_WAYS) : 1;
	localparam int SET_BITS      = $clog2(SET_COUNT);
	localparam int ENT_BITS      = $clog2(REQ_ENTRIES);
	localparam int REQ_BITS      = $clog2(REQUESTERS);
	localparam int TLB_IDX_BITS  = $clog2(TLB_TOTAL);
	localparam int FAULT_PENALTY = 100;

	// Operation codes.
	localparam logic [2:0] OP_TRANSLATE = 3'd0;
	localparam logic [2:0] OP_MAP       = 3'd1;
	localparam logic [2:0] OP_UNMAP     = 3'd2;
	localparam logic [2:0] OP_FLUSH     = 3'd3;
	localparam logic [2:0] OP_INSERT    = 3'd4;

	// Configuration register indexes.
	localparam logic REG_HIT_LAT  = 1'b0;
	localparam logic REG_WALK_LAT = 1'b1;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [1:0]  requester;
		logic [23:0] virt_addr;
		logic [11:0] virt_page;
		logic [15:0] phys_page_in;
	} in_item_t;

	typedef struct packed {
		logic [27:0] phys_addr;
		logic        tlb_hit;
		logic        page_fault;
		logic [10:0] latency_cycles;
	} out_item_t;

	typedef struct packed {
		logic                valid;
		logic [PPN_BITS-1:0] frame;
	} pt_word_t;

	typedef struct packed {
		logic [VPN_BITS-1:0] tag;
		logic [PPN_BITS-1:0] frame;
	} tlb_word_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK_RD,
		S_LOOK_CMP,
		S_PT_RD,
		S_PT_CMP,
		S_FILL,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DONE
	} state_t;

endpackage

// ----- sv/tlbw_ram.sv -----
// ----------------------------------------------------------------------------
// TLB with page table walk: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlbw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/tlb_with_page_table_walk.sv -----
// ----------------------------------------------------------------------------
// TLB with page table walk: top level
// Per-requester set-associative TLB with a directly indexed page table behind it.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-entry page table to clear its valid
// marks, one entry per cycle, and takes no item until the sweep is done
// (configuration writes are taken at any time). One item is in flight at a
// time, driven by a small sequencer around a single tag comparator and the
// two single-port-read RAMs. Map, flush and unknown operations go straight
// to the result; an insert writes the TLB first. A translate reads and
// compares one way at a time until it hits; a miss probes all 4 ways, then
// reads the page table, maps an unmapped page to itself and refills the TLB.
// An unmap sweeps all 256 TLB entries, reading and comparing each in turn.
// A finished result waits in an output register; the next item is taken meanwhile.
module tlb_with_page_table_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tlbw_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tlbw_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [9:0]          cfg_data
);
	import tlbw_pkg::*;

	`include "tlb_with_page_table_walk_defines.svh"

	state_t                  state_q, state_d;
	logic [7:0]              hit_lat_q;
	logic [9:0]              walk_lat_q;
	logic [2:0]              op_q;
	logic [REQ_BITS-1:0]     req_q;
	logic [VPN_BITS-1:0]     vpn_q;
	logic [OFFSET_BITS-1:0]  off_q;
	logic [PPN_BITS-1:0]     frame_q;
	logic [WAY_BITS-1:0]     way_q;
	logic [TLB_IDX_BITS-1:0] scan_q;
	logic [VPN_BITS-1:0]     clr_q;
	logic                    hit_q, fault_q, walk_q;
	logic [TLB_TOTAL-1:0]    tlb_valid_q;
	logic                    out_valid_q;
	out_item_t               out_data_q;

	logic                    accept;
	logic                    pt_we;
	logic [VPN_BITS-1:0]     pt_waddr, pt_raddr;
	pt_word_t                pt_wdata, pt_rdata;
	logic                    tlb_we;
	logic [TLB_IDX_BITS-1:0] tlb_raddr;
	tlb_word_t               tlb_wdata, tlb_rdata;
	logic [TLB_IDX_BITS-1:0] look_idx, fill_idx;
	logic [WAY_BITS-1:0]     fill_way;
	logic                    fill_found;
	logic                    tag_eq;
	logic                    out_free;
	logic [10:0]             lat_sum;

	// Memories: page table and TLB tag/frame store.
	tlbw_ram #(.WIDTH($bits(pt_word_t)), .DEPTH(PT_DEPTH)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	tlbw_ram #(.WIDTH($bits(tlb_word_t)), .DEPTH(TLB_TOTAL)) u_tlb_ram (
		.clk   (clk),
		.we    (tlb_we),
		.waddr (fill_idx),
		.wdata (tlb_wdata),
		.raddr (tlb_raddr),
		.rdata (tlb_rdata)
	);

	// Shared tag comparator, used by lookups and by the unmap sweep.
	assign tag_eq = (tlb_rdata.tag == vpn_q);

	// Entry index of the way being probed.
	assign look_idx = {req_q, vpn_q[SET_BITS-1:0], way_q};

	// Refill victim: first invalid way of the set, else way 0.
	always_comb begin
		fill_way   = '0;
		fill_found = 1'b0;
		for (int w = 0; w < EFF_WAYS; w++) begin
			if (!fill_found && !tlb_valid_q[{req_q, vpn_q[SET_BITS-1:0], WAY_BITS'(w)}]) begin
				fill_way   = WAY_BITS'(w);
				fill_found = 1'b1;
			end
		end
	end
	assign fill_idx  = {req_q, vpn_q[SET_BITS-1:0], fill_way};
	assign tlb_wdata = '{tag: vpn_q, frame: frame_q};

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Reported latency of the finished translate.
	assign lat_sum = 11'(hit_lat_q) + (walk_q ? 11'(walk_lat_q) : 11'd0)
		+ (fault_q ? 11'(FAULT_PENALTY) : 11'd0);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d   = state_q;
		pt_we     = 1'b0;
		pt_waddr  = vpn_q;
		pt_wdata  = '{valid: 1'b1, frame: frame_q};
		pt_raddr  = vpn_q;
		tlb_we    = 1'b0;
		tlb_raddr = look_idx;
		unique case (state_q)
			S_CLEAR: begin
				pt_we    = 1'b1;
				pt_waddr = clr_q;
				pt_wdata = '{valid: 1'b0, frame: '0};
				if (clr_q == {VPN_BITS{1'b1}}) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					priority case (in_data.opcode)
						OP_TRANSLATE: state_d = S_LOOK_RD;
						OP_MAP: begin
							pt_we    = 1'b1;
							pt_waddr = in_data.virt_page[VPN_BITS-1:0];
							pt_wdata = '{valid: 1'b1,
								frame: in_data.phys_page_in[PPN_BITS-1:0]};
							state_d  = S_DONE;
						end
						OP_UNMAP: begin
							pt_we    = 1'b1;
							pt_waddr = in_data.virt_page[VPN_BITS-1:0];
							pt_wdata = '{valid: 1'b0, frame: '0};
							state_d  = S_SCAN_RD;
						end
						OP_INSERT: state_d = S_FILL;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_LOOK_RD: begin
				tlb_raddr = look_idx;
				state_d   = S_LOOK_CMP;
			end
			S_LOOK_CMP: begin
				if (tlb_valid_q[look_idx] && tag_eq) begin
					state_d = S_DONE;
				end else if (way_q == WAY_BITS'(EFF_WAYS - 1)) begin
					state_d = S_PT_RD;
				end else begin
					state_d = S_LOOK_RD;
				end
			end
			S_PT_RD: begin
				pt_raddr = vpn_q;
				state_d  = S_PT_CMP;
			end
			S_PT_CMP: begin
				// An unmapped page gets an identity mapping.
				if (!pt_rdata.valid) begin
					pt_we    = 1'b1;
					pt_waddr = vpn_q;
					pt_wdata = '{valid: 1'b1, frame: PPN_BITS'(vpn_q)};
				end
				state_d = S_FILL;
			end
			S_FILL: begin
				tlb_we  = 1'b1;
				state_d = S_DONE;
			end
			S_SCAN_RD: begin
				tlb_raddr = scan_q;
				state_d   = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (scan_q == {TLB_IDX_BITS{1'b1}}) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_lat_q  <= 8'd1;
			walk_lat_q <= 10'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HIT_LAT:  hit_lat_q  <= cfg_data[7:0];
				REG_WALK_LAT: walk_lat_q <= cfg_data;
				default:      hit_lat_q  <= hit_lat_q;
			endcase
		end
	end

	// Clear sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == S_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// TLB valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlb_valid_q <= '0;
		end else begin
			if (accept && in_data.opcode == OP_FLUSH) begin
				for (int i = 0; i < REQ_ENTRIES; i++) begin
					tlb_valid_q[{in_data.requester[REQ_BITS-1:0], ENT_BITS'(i)}] <= 1'b0;
				end
			end
			if (state_q == S_FILL) begin
				tlb_valid_q[fill_idx] <= 1'b1;
			end
			if (state_q == S_SCAN_CMP && tlb_valid_q[scan_q] && tag_eq) begin
				tlb_valid_q[scan_q] <= 1'b0;
			end
		end
	end

	// Item registers and walk progress.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= in_data.opcode;
			req_q   <= in_data.requester[REQ_BITS-1:0];
			off_q   <= in_data.virt_addr[OFFSET_BITS-1:0];
			frame_q <= in_data.phys_page_in[PPN_BITS-1:0];
			way_q   <= '0;
			scan_q  <= '0;
			hit_q   <= 1'b0;
			fault_q <= 1'b0;
			walk_q  <= 1'b0;
			if (in_data.opcode == OP_TRANSLATE) begin
				vpn_q <= in_data.virt_addr[OFFSET_BITS +: VPN_BITS];
			end else begin
				vpn_q <= in_data.virt_page[VPN_BITS-1:0];
			end
		end else begin
			unique case (state_q)
				S_LOOK_CMP: begin
					if (tlb_valid_q[look_idx] && tag_eq) begin
						hit_q   <= 1'b1;
						frame_q <= tlb_rdata.frame;
					end else begin
						way_q <= way_q + 1'b1;
					end
				end
				S_PT_CMP: begin
					walk_q <= 1'b1;
					if (pt_rdata.valid) begin
						frame_q <= pt_rdata.frame;
					end else begin
						fault_q <= 1'b1;
						frame_q <= PPN_BITS'(vpn_q);
					end
				end
				S_SCAN_CMP: scan_q <= scan_q + 1'b1;
				default:    scan_q <= scan_q;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			if (op_q == OP_TRANSLATE) begin
				out_data_q.phys_addr      <= 28'({frame_q, off_q});
				out_data_q.tlb_hit        <= hit_q;
				out_data_q.page_fault     <= fault_q;
				out_data_q.latency_cycles <= lat_sum;
			end else begin
				out_data_q <= '0;
			end
		end
	end

	// Checks on the sequencer.
	`TLBW_ASSERT_IMP(a_hit_no_fault, clk, arst_n, out_valid, !(out_data.tlb_hit && out_data.page_fault))
	`TLBW_ASSERT_NEXT(a_fill_sets_valid, clk, arst_n, state_q == S_FILL, tlb_valid_q[$past(fill_idx)])
	`TLBW_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != S_IDLE)

endmodule

// ----- tb/tlb_translation_checker.sv -----
// ----------------------------------------------------------------------------
// TLB with page table walk: translation checker
// Watches the item and result channels, keeps its own copy of the TLBs, the
// page table and the latency registers, and compares every result in order.
// ----------------------------------------------------------------------------
module tlb_translation_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  tlbw_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  tlbw_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [9:0]          cfg_data,
	output int                  fail_count,
	output int                  pending_count,
	output int                  result_count,
	output int                  hit_count,
	output int                  fault_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import tlbw_pkg::*;

	logic [7:0]          hit_lat;
	logic [9:0]          walk_lat;
	logic                pt_valid  [PT_DEPTH];
	logic [PPN_BITS-1:0] pt_frame  [PT_DEPTH];
	logic                tlb_valid [TLB_TOTAL];
	logic [VPN_BITS-1:0] tlb_tag   [TLB_TOTAL];
	logic [PPN_BITS-1:0] tlb_frame [TLB_TOTAL];
	out_item_t           expected_results[$];

	assign pending_count = expected_results.size();

	function automatic int set_base(int req, logic [VPN_BITS-1:0] vpn);
		return req * REQ_ENTRIES + int'(vpn % SET_COUNT) * EFF_WAYS;
	endfunction

	// Refill picks the first free way of the set, or else way 0.
	task automatic fill_way(int req, logic [VPN_BITS-1:0] vpn, logic [PPN_BITS-1:0] frame);
		int base;
		int pick;
		base = set_base(req, vpn);
		pick = base;
		for (int w = EFF_WAYS - 1; w >= 0; w--)
			if (!tlb_valid[base + w])
				pick = base + w;
		tlb_valid[pick] = 1'b1;
		tlb_tag[pick]   = vpn;
		tlb_frame[pick] = frame;
	endtask

	task automatic translate_item(in_item_t it);
		out_item_t           res;
		int                  req;
		int                  base;
		logic [VPN_BITS-1:0] vpn;
		logic [PPN_BITS-1:0] frame;
		logic                found;
		res   = '0;
		req   = int'(it.requester) % REQUESTERS;
		found = 1'b0;
		frame = '0;
		case (it.opcode)
			OP_TRANSLATE: begin
				vpn  = it.virt_addr[OFFSET_BITS +: VPN_BITS];
				base = set_base(req, vpn);
				for (int w = 0; w < EFF_WAYS; w++)
					if (!found && tlb_valid[base + w] && tlb_tag[base + w] == vpn) begin
						found = 1'b1;
						frame = tlb_frame[base + w];
					end
				if (found) begin
					res.tlb_hit        = 1'b1;
					res.latency_cycles = 11'(hit_lat);
				end else if (pt_valid[vpn]) begin
					frame = pt_frame[vpn];
					fill_way(req, vpn, frame);
					res.latency_cycles = 11'(hit_lat) + 11'(walk_lat);
				end else begin
					// Unmapped page: identity mapping in both stores.
					frame         = PPN_BITS'(vpn);
					pt_valid[vpn] = 1'b1;
					pt_frame[vpn] = frame;
					fill_way(req, vpn, frame);
					res.page_fault     = 1'b1;
					res.latency_cycles = 11'(hit_lat) + 11'(walk_lat) + 11'(FAULT_PENALTY);
				end
				res.phys_addr = 28'({frame, it.virt_addr[OFFSET_BITS-1:0]});
			end
			OP_MAP: begin
				pt_valid[it.virt_page] = 1'b1;
				pt_frame[it.virt_page] = it.phys_page_in;
			end
			OP_UNMAP: begin
				pt_valid[it.virt_page] = 1'b0;
				for (int i = 0; i < TLB_TOTAL; i++)
					if (tlb_valid[i] && tlb_tag[i] == it.virt_page)
						tlb_valid[i] = 1'b0;
			end
			OP_FLUSH: begin
				for (int i = 0; i < REQ_ENTRIES; i++)
					tlb_valid[req * REQ_ENTRIES + i] = 1'b0;
			end
			OP_INSERT: fill_way(req, it.virt_page, it.phys_page_in);
			default: ;
		endcase
		expected_results.push_back(res);
	endtask

	// Observe every transfer on the three channels.
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_res;
		if (!arst_n) begin
			hit_lat      = 8'd1;
			walk_lat     = 10'd100;
			fail_count   = 0;
			result_count = 0;
			hit_count    = 0;
			fault_count  = 0;
			expected_results.delete();
			for (int i = 0; i < PT_DEPTH; i++) begin
				pt_valid[i] = 1'b0;
				pt_frame[i] = '0;
			end
			for (int i = 0; i < TLB_TOTAL; i++) begin
				tlb_valid[i] = 1'b0;
				tlb_tag[i]   = '0;
				tlb_frame[i] = '0;
			end
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Unexpected result %h", out_data);
				end else begin
					exp_res = expected_results.pop_front();
					if (exp_res.tlb_hit)
						hit_count++;
					if (exp_res.page_fault)
						fault_count++;
					if (out_data.phys_addr !== exp_res.phys_addr
							|| out_data.tlb_hit !== exp_res.tlb_hit
							|| out_data.page_fault !== exp_res.page_fault
							|| out_data.latency_cycles !== exp_res.latency_cycles) begin
						fail_count++;
						if (fail_count <= 10)
							$display("Mismatch: expected pa=%h hit=%b fault=%b lat=%0d,",
								exp_res.phys_addr, exp_res.tlb_hit, exp_res.page_fault,
								exp_res.latency_cycles,
								" got pa=%h hit=%b fault=%b lat=%0d",
								out_data.phys_addr, out_data.tlb_hit,
								out_data.page_fault, out_data.latency_cycles);
					end
				end
			end
			if (in_valid && !in_stall)
				translate_item(in_data);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_HIT_LAT)
					hit_lat = cfg_data[7:0];
				else
					walk_lat = cfg_data;
			end
		end
	end
endmodule

// ----- tb/tb_tlb_with_page_table_walk.sv -----
// ----------------------------------------------------------------------------
// TLB with page table walk: testbench top
// Drives directed and random operations with random idling on both channels,
// changes the latency registers between phases, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_tlb_with_page_table_walk;
	timeunit 1ns;
	timeprecision 1ps;
	import tlbw_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_index = REG_HIT_LAT;
	logic [9:0] cfg_data = '0;
	int        fail_count;
	int        pending_count;
	int        result_count;
	int        hit_count;
	int        fault_count;
	int        cycle_count = 0;
	int        idle_pct = 36;
	int        sent_count = 0;
	logic [11:0] hot_pages[8];

	always #1 clk = ~clk;

	tlb_with_page_table_walk dut (.*);

	tlb_translation_checker checker_i (.*);

	// Run-away guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// The receiver stalls at random.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < idle_pct);

	// Valid is left high after the transfer; the next call or the drain
	// drops it, so the block never sees the same item twice.
	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t make_item(logic [2:0] op, logic [1:0] req,
			logic [23:0] va, logic [11:0] vp, logic [15:0] pp);
		in_item_t it;
		it.opcode       = op;
		it.requester    = req;
		it.virt_addr    = va;
		it.virt_page    = vp;
		it.phys_page_in = pp;
		return it;
	endfunction

	// Mostly operations on a small pool of pages so that hits, refills and
	// set conflicts happen often; a few items are fully random noise.
	function automatic in_item_t random_item();
		in_item_t    it;
		logic [63:0] raw;
		logic [11:0] vp;
		int          pick;
		raw  = {$urandom, $urandom};
		it   = raw[$bits(in_item_t)-1:0];
		vp   = hot_pages[$urandom_range(7)];
		pick = $urandom_range(99);
		if (pick < 55) begin
			it.opcode    = OP_TRANSLATE;
			it.virt_addr = {vp, it.virt_addr[11:0]};
		end else if (pick < 70) begin
			it.opcode    = OP_MAP;
			it.virt_page = vp;
		end else if (pick < 80) begin
			it.opcode    = OP_INSERT;
			it.virt_page = vp;
		end else if (pick < 83) begin
			it.opcode    = OP_UNMAP;
			it.virt_page = vp;
		end else if (pick < 86) begin
			it.opcode = OP_FLUSH;
		end else if (pick < 90) begin
			it.opcode = 3'($urandom_range(7, 5));
		end
		return it;
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 8; i++)
			hot_pages[i] = (i < 6) ? 12'(i * SET_COUNT + 3) : 12'($urandom);

		// Directed: faults, walks, hits, extremes and every operation.
		send_item(make_item(OP_TRANSLATE, 2'd0, 24'h000000, 12'h000, 16'h0000));
		send_item(make_item(OP_TRANSLATE, 2'd0, 24'h000fff, 12'h000, 16'h0000));
		send_item(make_item(OP_TRANSLATE, 2'd3, 24'hffffff, 12'hfff, 16'hffff));
		send_item(make_item(OP_MAP, 2'd1, 24'h0, 12'hfff, 16'hffff));
		send_item(make_item(OP_TRANSLATE, 2'd1, 24'hfff123, 12'h0, 16'h0));
		send_item(make_item(OP_MAP, 2'd1, 24'h0, 12'hfff, 16'h1234));
		send_item(make_item(OP_TRANSLATE, 2'd1, 24'hfff456, 12'h0, 16'h0));
		send_item(make_item(OP_INSERT, 2'd2, 24'h0, 12'h010, 16'haaaa));
		send_item(make_item(OP_INSERT, 2'd2, 24'h0, 12'h010, 16'h5555));
		send_item(make_item(OP_TRANSLATE, 2'd2, 24'h010abc, 12'h0, 16'h0));
		for (int w = 0; w < 5; w++)
			send_item(make_item(OP_INSERT, 2'd0, 24'h0, 12'(w * SET_COUNT + 5), 16'(w)));
		send_item(make_item(OP_TRANSLATE, 2'd0, 24'h005000, 12'h0, 16'h0));
		send_item(make_item(OP_UNMAP, 2'd0, 24'h0, 12'hfff, 16'h0));
		send_item(make_item(OP_TRANSLATE, 2'd1, 24'hfff000, 12'h0, 16'h0));
		send_item(make_item(OP_FLUSH, 2'd2, 24'h0, 12'h0, 16'h0));
		send_item(make_item(OP_TRANSLATE, 2'd2, 24'h010001, 12'h0, 16'h0));
		send_item(make_item(3'd5, 2'd1, 24'hffffff, 12'hfff, 16'hffff));
		send_item(make_item(3'd7, 2'd3, 24'h0, 12'h0, 16'h0));

		// Sender holds off until every result is back, then latency extremes.
		drain_results();
		write_reg(REG_HIT_LAT, 10'd255);
		write_reg(REG_WALK_LAT, 10'd1023);
		send_item(make_item(OP_TRANSLATE, 2'd3, 24'h123456, 12'h0, 16'h0));
		send_item(make_item(OP_TRANSLATE, 2'd3, 24'h123456, 12'h0, 16'h0));
		send_item(make_item(OP_TRANSLATE, 2'd0, 24'hffffff, 12'h0, 16'h0));

		// Random phases under several register settings.
		for (int ph = 0; ph < 5; ph++) begin
			drain_results();
			case (ph)
				0: begin write_reg(REG_HIT_LAT, 10'd0); write_reg(REG_WALK_LAT, 10'd0); end
				1: begin write_reg(REG_HIT_LAT, 10'($urandom)); write_reg(REG_WALK_LAT, 10'($urandom)); end
				2: begin write_reg(REG_HIT_LAT, 10'h3ff); write_reg(REG_WALK_LAT, 10'd512); end
				3: begin write_reg(REG_HIT_LAT, 10'd1); write_reg(REG_WALK_LAT, 10'd100); end
				default: begin write_reg(REG_HIT_LAT, 10'd200); write_reg(REG_WALK_LAT, 10'd900); end
			endcase
			idle_pct = (ph == 2) ? 0 : 36;
			for (int i = 0; i < 200; i++)
				send_item(random_item());
		end

		drain_results();
		repeat (600) @(posedge clk);
		$display("Sent %0d operations over seven latency settings:", sent_count);
		$display("%0d results, %0d hits, %0d faults.", result_count, hit_count, fault_count);
		if (fail_count == 0 && pending_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
